// ===== rtl/dpb_pkg.sv =====
// Package for the depth pixel back-projection block.
// Holds register indexes, reset values, arithmetic constants and the side-band packet type.
// No dependencies; used by dpb_div, depth_pixel_backprojection and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_WIN_LO    = 3'd0;
    localparam logic [2:0] REG_WIN_HI    = 3'd1;
    localparam logic [2:0] REG_PP_COL    = 3'd2;
    localparam logic [2:0] REG_PP_ROW    = 3'd3;
    localparam logic [2:0] REG_FOCAL_PX  = 3'd4;
    localparam logic [2:0] REG_RADIUS_MM = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the registers.
    localparam logic [15:0] RST_WIN_LO    = 16'd0;
    localparam logic [15:0] RST_WIN_HI    = 16'd2000;
    localparam logic [11:0] RST_PP_COL    = 12'd320;
    localparam logic [11:0] RST_PP_ROW    = 12'd240;
    localparam logic [11:0] RST_FOCAL_PX  = 12'd528;
    localparam logic [7:0]  RST_RADIUS_MM = 8'd25;

    // Pi as a ratio of integers.
    localparam logic [14:0] PI_NUM = 15'd31415;
    localparam logic [13:0] PI_DEN = 14'd10000;

    // Quotient bits produced by every divider, one per pipeline stage.
    localparam int QUO_W = 34;

    // Divisor widths of the dividers; the x and y dividers share POS_DEN_W.
    localparam int POS_DEN_W = 13;
    localparam int RAD_DEN_W = 17;
    localparam int DNS_DEN_W = 55;

    // Side-band information that travels alongside the dividers.
    typedef struct packed {
        logic        acc;
        logic        neg_x;
        logic        neg_y;
        logic        sat;
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pkt_t;

endpackage

`default_nettype wire

// ===== rtl/dpb_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on dpb_pkg for nothing but style; parameters set all widths.
`timescale 1ns / 1ps
`default_nettype none

module dpb_div
    import dpb_pkg::*;
#(
    parameter int DEN_W = 16,
    parameter int Q_W   = 34
)
(
    input  wire logic             clk,
    input  wire logic [DEN_W-1:0] rem_in,
    input  wire logic [Q_W-1:0]   num_in,
    input  wire logic [DEN_W-1:0] den_in,
    output logic      [Q_W-1:0]   quo
);

    // The starting remainder must be below the divisor.
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   num_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic [DEN_W-1:0] cur_rem;
            logic [Q_W-1:0]   cur_num;
            logic [DEN_W-1:0] cur_den;
            logic [Q_W-1:0]   cur_quo;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             fits;

            if (k == 0) begin : g_first
                assign cur_rem = rem_in;
                assign cur_num = num_in;
                assign cur_den = den_in;
                assign cur_quo = '0;
            end
            else begin : g_next
                assign cur_rem = rem_reg[k-1];
                assign cur_num = num_reg[k-1];
                assign cur_den = den_reg[k-1];
                assign cur_quo = quo_reg[k-1];
            end

            assign trial = {cur_rem, cur_num[Q_W-1]};
            assign diff  = trial - {1'b0, cur_den};
            assign fits  = (trial >= {1'b0, cur_den});

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[k] <= {cur_num[Q_W-2:0], 1'b0};
                den_reg[k] <= cur_den;
                quo_reg[k] <= {cur_quo[Q_W-2:0], fits};
            end
        end
    endgenerate

    assign quo = quo_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection pipeline.
// Depends on dpb_pkg and dpb_div.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+---------------------------------------------
//   pixel    | start / busy       | pixel_x, pixel_y, depth_mm, red, green, blue
//   result   | done (strobe)      | valid_res, pos_x, pos_y, pos_z, color_r/g/b,
//            |                    | radius_px, density
//   config   | cfg_we             | cfg_addr, cfg_wdata
//
// One pixel may be transferred in every clock cycle; busy is never raised.
// Each result is on the ports for its strobe cycle and is transferred at the edge
// that ends it. Between pixel and result lie five set-up stages (input register,
// products, sums, the density divisor product, the saturation compare), 34 stages
// of bit-per-stage division and one output register. The division stages set the
// latency; throughput is one per clock.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall, so the pipeline advances unconditionally.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [11:0]           pixel_x,
    input  wire logic [11:0]           pixel_y,
    input  wire logic [15:0]           depth_mm,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    output logic                       done,
    output logic                       valid_res,
    output logic signed [23:0]         pos_x,
    output logic signed [23:0]         pos_y,
    output logic [19:0]                pos_z,
    output logic [15:0]                color_r,
    output logic [15:0]                color_g,
    output logic [15:0]                color_b,
    output logic [31:0]                radius_px,
    output logic [31:0]                density,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes to unknown indexes are dropped.
    // ------------------------------------------------------------------
    logic [15:0] win_lo_reg;
    logic [15:0] win_hi_reg;
    logic [11:0] pp_col_reg;
    logic [11:0] pp_row_reg;
    logic [11:0] focal_px_reg;
    logic [7:0]  radius_mm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lo_reg    <= RST_WIN_LO;
            win_hi_reg    <= RST_WIN_HI;
            pp_col_reg    <= RST_PP_COL;
            pp_row_reg    <= RST_PP_ROW;
            focal_px_reg  <= RST_FOCAL_PX;
            radius_mm_reg <= RST_RADIUS_MM;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIN_LO:    win_lo_reg    <= cfg_wdata;
                REG_WIN_HI:    win_hi_reg    <= cfg_wdata;
                REG_PP_COL:    pp_col_reg    <= cfg_wdata[11:0];
                REG_PP_ROW:    pp_row_reg    <= cfg_wdata[11:0];
                REG_FOCAL_PX:  focal_px_reg  <= cfg_wdata[11:0];
                REG_RADIUS_MM: radius_mm_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // A focal length or radius of zero behaves as one.
    logic [11:0] focal_eff;
    logic [7:0]  radius_eff;
    assign focal_eff  = (focal_px_reg == '0)  ? 12'd1 : focal_px_reg;
    assign radius_eff = (radius_mm_reg == '0) ? 8'd1  : radius_mm_reg;

    assign busy = 1'b0;

    logic in_xfer;
    assign in_xfer = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: acceptance test and offsets from the principal point.
    // ------------------------------------------------------------------
    logic        v1_reg;
    pkt_t        s1_pkt_reg;
    logic [11:0] s1_mag_x_reg;
    logic [11:0] s1_mag_y_reg;
    logic [11:0] s1_f_reg;
    logic [7:0]  s1_rad_reg;

    logic        neg_x_next;
    logic        neg_y_next;
    logic        acc_next;
    pkt_t        s1_pkt_next;

    always_comb
    begin
        neg_x_next = pixel_x < pp_col_reg;
        neg_y_next = pixel_y < pp_row_reg;
        acc_next   = (depth_mm != '0) && (depth_mm >= win_lo_reg)
                     && (depth_mm <= win_hi_reg);
        s1_pkt_next.acc   = acc_next;
        s1_pkt_next.neg_x = neg_x_next;
        s1_pkt_next.neg_y = neg_y_next;
        s1_pkt_next.sat   = 1'b0;
        s1_pkt_next.depth = depth_mm;
        s1_pkt_next.red   = red;
        s1_pkt_next.green = green;
        s1_pkt_next.blue  = blue;
    end

    always_ff @(posedge clk)
    begin
        s1_pkt_reg   <= s1_pkt_next;
        s1_mag_x_reg <= neg_x_next ? (pp_col_reg - pixel_x) : (pixel_x - pp_col_reg);
        s1_mag_y_reg <= neg_y_next ? (pp_row_reg - pixel_y) : (pixel_y - pp_row_reg);
        s1_f_reg     <= focal_eff;
        s1_rad_reg   <= radius_eff;
    end

    // ------------------------------------------------------------------
    // Stage 2: the narrow products.
    // ------------------------------------------------------------------
    logic        v2_reg;
    pkt_t        s2_pkt_reg;
    logic [27:0] s2_px_reg;
    logic [27:0] s2_py_reg;
    logic [31:0] s2_dd_reg;
    logic [15:0] s2_rr_reg;
    logic [23:0] s2_ff_reg;
    logic [19:0] s2_rf_reg;
    logic [11:0] s2_f_reg;

    always_ff @(posedge clk)
    begin
        s2_pkt_reg <= s1_pkt_reg;
        s2_px_reg  <= 28'(s1_mag_x_reg) * 28'(s1_pkt_reg.depth);
        s2_py_reg  <= 28'(s1_mag_y_reg) * 28'(s1_pkt_reg.depth);
        s2_dd_reg  <= 32'(s1_pkt_reg.depth) * 32'(s1_pkt_reg.depth);
        s2_rr_reg  <= 16'(s1_rad_reg) * 16'(s1_rad_reg);
        s2_ff_reg  <= 24'(s1_f_reg) * 24'(s1_f_reg);
        s2_rf_reg  <= 20'(s1_rad_reg) * 20'(s1_f_reg);
        s2_f_reg   <= s1_f_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: rounding numerators and the density products.
    // ------------------------------------------------------------------
    logic        v3_reg;
    pkt_t        s3_pkt_reg;
    logic [33:0] s3_nx_reg;
    logic [33:0] s3_ny_reg;
    logic [29:0] s3_nr_reg;
    logic [45:0] s3_nn_reg;
    logic [39:0] s3_dp_reg;
    logic [11:0] s3_f_reg;

    always_ff @(posedge clk)
    begin
        s3_pkt_reg <= s2_pkt_reg;
        // 2*16*p + f, so that the quotient by 2f rounds to nearest.
        s3_nx_reg  <= 34'({s2_px_reg, 5'b0}) + 34'(s2_f_reg);
        s3_ny_reg  <= 34'({s2_py_reg, 5'b0}) + 34'(s2_f_reg);
        s3_nr_reg  <= 30'({s2_rf_reg, 9'b0}) + 30'(s2_pkt_reg.depth);
        s3_nn_reg  <= 46'(s2_dd_reg) * 46'(PI_DEN);
        s3_dp_reg  <= 40'(s2_rr_reg) * 40'(s2_ff_reg);
        s3_f_reg   <= s2_f_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: the density divisor.
    // ------------------------------------------------------------------
    logic                 v4_reg;
    pkt_t                 s4_pkt_reg;
    logic [33:0]          s4_nx_reg;
    logic [33:0]          s4_ny_reg;
    logic [29:0]          s4_nr_reg;
    logic [45:0]          s4_nn_reg;
    logic [DNS_DEN_W-1:0] s4_den_reg;
    logic [11:0]          s4_f_reg;

    always_ff @(posedge clk)
    begin
        s4_pkt_reg <= s3_pkt_reg;
        s4_nx_reg  <= s3_nx_reg;
        s4_ny_reg  <= s3_ny_reg;
        s4_nr_reg  <= s3_nr_reg;
        s4_nn_reg  <= s3_nn_reg;
        s4_den_reg <= DNS_DEN_W'(s3_dp_reg) * DNS_DEN_W'(PI_NUM);
        s4_f_reg   <= s3_f_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: density saturation test and divider operands.
    // ------------------------------------------------------------------
    logic                 v5_reg;
    pkt_t                 s5_pkt_reg;
    logic [33:0]          s5_nx_reg;
    logic [33:0]          s5_ny_reg;
    logic [29:0]          s5_nr_reg;
    logic [DNS_DEN_W-1:0] s5_r0_reg;
    logic [DNS_DEN_W-1:0] s5_den_reg;
    logic [11:0]          s5_f_reg;
    logic                 sat_next;
    pkt_t                 s5_pkt_next;

    always_comb
    begin
        sat_next        = DNS_DEN_W'(s4_nn_reg) >= s4_den_reg;
        s5_pkt_next     = s4_pkt_reg;
        s5_pkt_next.sat = sat_next;
    end

    always_ff @(posedge clk)
    begin
        s5_pkt_reg <= s5_pkt_next;
        s5_nx_reg  <= s4_nx_reg;
        s5_ny_reg  <= s4_ny_reg;
        s5_nr_reg  <= s4_nr_reg;
        // The divider needs a starting remainder below the divisor.
        s5_r0_reg  <= sat_next ? '0 : DNS_DEN_W'(s4_nn_reg);
        s5_den_reg <= s4_den_reg;
        s5_f_reg   <= s4_f_reg;
    end

    // Valid bits of the set-up stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Division stages. All four dividers share one quotient width, QUO_W, and so one depth.
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic [QUO_W-1:0] quo_r;
    logic [QUO_W-1:0] quo_d;

    dpb_div #(.DEN_W(POS_DEN_W), .Q_W(QUO_W)) u_div_x
    (
        .clk    (clk),
        .rem_in ('0),
        .num_in (s5_nx_reg),
        .den_in ({s5_f_reg, 1'b0}),
        .quo    (quo_x)
    );

    dpb_div #(.DEN_W(POS_DEN_W), .Q_W(QUO_W)) u_div_y
    (
        .clk    (clk),
        .rem_in ('0),
        .num_in (s5_ny_reg),
        .den_in ({s5_f_reg, 1'b0}),
        .quo    (quo_y)
    );

    dpb_div #(.DEN_W(RAD_DEN_W), .Q_W(QUO_W)) u_div_r
    (
        .clk    (clk),
        .rem_in ('0),
        .num_in (QUO_W'(s5_nr_reg)),
        .den_in ({s5_pkt_reg.depth, 1'b0}),
        .quo    (quo_r)
    );

    // Fractional division: shifting in zeros gives floor(n * 2^34 / den).
    dpb_div #(.DEN_W(DNS_DEN_W), .Q_W(QUO_W)) u_div_d
    (
        .clk    (clk),
        .rem_in (s5_r0_reg),
        .num_in ('0),
        .den_in (s5_den_reg),
        .quo    (quo_d)
    );

    // Side-band delay line matching the divider latency.
    pkt_t dl_pkt_reg [QUO_W];
    logic [QUO_W-1:0] dl_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_vld_reg <= '0;
        end
        else
        begin
            dl_vld_reg <= {dl_vld_reg[QUO_W-2:0], v5_reg};
        end
    end

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_delay
            if (j == 0) begin : g_head
                always_ff @(posedge clk)
                begin
                    dl_pkt_reg[j] <= s5_pkt_reg;
                end
            end
            else begin : g_tail
                always_ff @(posedge clk)
                begin
                    dl_pkt_reg[j] <= dl_pkt_reg[j-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage: rounding, saturation and zeroing of rejected pixels.
    // ------------------------------------------------------------------
    pkt_t        fin;
    logic [23:0] pos_x_next;
    logic [23:0] pos_y_next;
    logic [31:0] dens_next;
    logic [33:0] dens_inc;

    assign fin = dl_pkt_reg[QUO_W-1];

    always_comb
    begin
        if (fin.neg_x)
            pos_x_next = (quo_x >= 34'h800000) ? 24'h800000 : 24'(-quo_x[23:0]);
        else
            pos_x_next = (quo_x > 34'h7FFFFF) ? 24'h7FFFFF : quo_x[23:0];

        if (fin.neg_y)
            pos_y_next = (quo_y >= 34'h800000) ? 24'h800000 : 24'(-quo_y[23:0]);
        else
            pos_y_next = (quo_y > 34'h7FFFFF) ? 24'h7FFFFF : quo_y[23:0];

        // Drop the extra quotient bit, then round half up.
        dens_inc = {1'b0, quo_d[33:1]} + 34'd1;
        if (fin.sat || dens_inc[33])
            dens_next = 32'hFFFF_FFFF;
        else
            dens_next = dens_inc[32:1];
    end

    logic        done_reg;
    logic        valid_res_reg;
    logic [23:0] pos_x_reg;
    logic [23:0] pos_y_reg;
    logic [19:0] pos_z_reg;
    logic [15:0] color_r_reg;
    logic [15:0] color_g_reg;
    logic [15:0] color_b_reg;
    logic [31:0] radius_px_reg;
    logic [31:0] density_reg;
    logic        keep;

    assign keep = dl_vld_reg[QUO_W-1] && fin.acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            valid_res_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= dl_vld_reg[QUO_W-1];
            valid_res_reg <= keep;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg     <= keep ? pos_x_next : '0;
        pos_y_reg     <= keep ? pos_y_next : '0;
        pos_z_reg     <= keep ? {fin.depth, 4'b0} : '0;
        color_r_reg   <= keep ? {fin.red, fin.red} : '0;
        color_g_reg   <= keep ? {fin.green, fin.green} : '0;
        color_b_reg   <= keep ? {fin.blue, fin.blue} : '0;
        radius_px_reg <= keep ? quo_r[31:0] : '0;
        density_reg   <= keep ? dens_next : '0;
    end

    assign done      = done_reg;
    assign valid_res = valid_res_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign color_r   = color_r_reg;
    assign color_g   = color_g_reg;
    assign color_b   = color_b_reg;
    assign radius_px = radius_px_reg;
    assign density   = density_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_valid_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_res |-> done)
        else $error("valid_res raised without a result strobe");

    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        valid_res |-> (pos_z != '0))
        else $error("accepted pixel carries zero depth");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (radius_px == '0 && density == '0 && pos_z == '0))
        else $error("rejected pixel has nonzero fields");

    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dl_vld_reg[QUO_W-1]))
        else $error("result strobe without a pipeline item");

endmodule

`default_nettype wire

// ===== test/depth_pixel_backprojection_tb.sv =====
// Self-checking testbench for the depth pixel back-projection pipeline.
// Depends on dpb_pkg and the depth_pixel_backprojection RTL.
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb;
    import dpb_pkg::*;

    // A projected point with its colour and footprint, as the block emits it.
    typedef struct packed {
        logic        valid_res;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [19:0] pos_z;
        logic [15:0] color_r;
        logic [15:0] color_g;
        logic [15:0] color_b;
        logic [31:0] radius_px;
        logic [31:0] density;
    } point_t;

    // The scoreboard keeps its own copy of the camera registers, works out the
    // point for every transferred pixel and checks the points in order.
    class point_scoreboard;
        logic [15:0] win_lo, win_hi;
        logic [11:0] pp_col, pp_row, focal_px;
        logic [7:0]  radius_mm;
        point_t      pending_points[$];
        int          mismatches;

        function void load_defaults();
            win_lo    = RST_WIN_LO;
            win_hi    = RST_WIN_HI;
            pp_col    = RST_PP_COL;
            pp_row    = RST_PP_ROW;
            focal_px  = RST_FOCAL_PX;
            radius_mm = RST_RADIUS_MM;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_WIN_LO:    win_lo    = val;
                REG_WIN_HI:    win_hi    = val;
                REG_PP_COL:    pp_col    = val[11:0];
                REG_PP_ROW:    pp_row    = val[11:0];
                REG_FOCAL_PX:  focal_px  = val[11:0];
                REG_RADIUS_MM: radius_mm = val[7:0];
                default: ;
            endcase
        endfunction

        // One axis of the pinhole projection, rounded and clamped to 24 bits.
        function logic [23:0] project(logic [15:0] d, logic [11:0] p, logic [11:0] c,
                                      logic [63:0] f);
            logic [63:0] mag, q;
            mag = (p < c) ? 64'(c - p) : 64'(p - c);
            q = (2 * (64'(d) * 16 * mag) + f) / (2 * f);
            if (p < c)
                return (q >= 64'd8388608) ? 24'h800000 : 24'(64'h1000000 - q);
            return (q > 64'd8388607) ? 24'h7FFFFF : q[23:0];
        endfunction

        function void note_pixel(logic [11:0] px, logic [11:0] py, logic [15:0] d,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            point_t      pt;
            logic [63:0] f, rad, num, q, n, den, rem;
            pt = '0;
            f   = (focal_px == 0) ? 64'd1 : 64'(focal_px);
            rad = (radius_mm == 0) ? 64'd1 : 64'(radius_mm);
            if (d != 0 && d >= win_lo && d <= win_hi) begin
                pt.valid_res = 1'b1;
                pt.pos_x   = project(d, px, pp_col, f);
                pt.pos_y   = project(d, py, pp_row, f);
                pt.pos_z   = 20'(64'(d) * 16);
                pt.color_r = 16'(r) * 16'd257;
                pt.color_g = 16'(g) * 16'd257;
                pt.color_b = 16'(b) * 16'd257;
                num = rad * f * 256;
                q = (2 * num + 64'(d)) / (2 * 64'(d));
                pt.radius_px = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
                n   = 64'(d) * 64'(d) * 64'(PI_DEN);
                den = 64'(PI_NUM) * rad * rad * f * f;
                if (n >= den) begin
                    pt.density = 32'hFFFFFFFF;
                end
                else begin
                    // Restoring division giving one guard bit for rounding.
                    rem = n;
                    q = 0;
                    for (int i = 0; i < 33; i++) begin
                        rem = rem << 1;
                        q = q << 1;
                        if (rem >= den) begin
                            rem = rem - den;
                            q[0] = 1'b1;
                        end
                    end
                    q = (q + 1) >> 1;
                    pt.density = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
                end
            end
            pending_points.insert(pending_points.size(), pt);
        endfunction

        function bit check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point %h with nothing pending", got);
                return 0;
            end
            want = pending_points.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"point mismatch: valid %b/%b x %h/%h y %h/%h z %h/%h ",
                              "rgb %h%h%h/%h%h%h rad %h/%h dens %h/%h (exp/act)"},
                             want.valid_res, got.valid_res, want.pos_x, got.pos_x,
                             want.pos_y, got.pos_y, want.pos_z, got.pos_z,
                             want.color_r, want.color_g, want.color_b,
                             got.color_r, got.color_g, got.color_b,
                             want.radius_px, got.radius_px, want.density, got.density);
                return 0;
            end
            return 1;
        endfunction
    endclass

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] pixel_x = '0, pixel_y = '0;
    logic [15:0] depth_mm = '0;
    logic [7:0]  red = '0, green = '0, blue = '0;
    logic        done, valid_res;
    logic signed [23:0] pos_x, pos_y;
    logic [19:0] pos_z;
    logic [15:0] color_r, color_g, color_b;
    logic [31:0] radius_px, density;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    point_scoreboard points = new();
    int  idle_cycles;
    bit  calm_stretch;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    depth_pixel_backprojection i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .depth_mm(depth_mm),
        .red(red), .green(green), .blue(blue),
        .done(done), .valid_res(valid_res), .pos_x(pos_x), .pos_y(pos_y),
        .pos_z(pos_z), .color_r(color_r), .color_g(color_g), .color_b(color_b),
        .radius_px(radius_px), .density(density),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Results are sampled on the rising edge that ends their strobe cycle. The
    // watchdog counts edges at which neither a pixel nor a point is transferred.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                void'(points.check_point({valid_res, pos_x, pos_y, pos_z, color_r,
                                          color_g, color_b, radius_px, density}));
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Register writes happen only with the pipeline drained.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        points.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Waits until every point is back, then lets the pipeline empty fully.
    // The caller is at a falling edge, so start drops before the next rising edge.
    task automatic drain();
        start = 1'b0;
        while (points.pending_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // Presents one pixel from the falling edge and holds it until transferred.
    // The caller is at a falling edge; start stays high across back-to-back pixels.
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [15:0] d,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!calm_stretch && $urandom_range(99) < 19) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        pixel_x = px;
        pixel_y = py;
        depth_mm = d;
        red = r;
        green = g;
        blue = b;
        @(posedge clk);
        while (busy) @(posedge clk);
        points.note_pixel(px, py, d, r, g, b);
        @(negedge clk);
    endtask

    // Mostly in-window depths at random coordinates, with some edge cases.
    task automatic random_pixel();
        logic [15:0] d;
        case ($urandom_range(9))
            0:       d = 16'($urandom);
            1:       d = 16'd0;
            2:       d = points.win_lo;
            3:       d = points.win_hi;
            default: d = (points.win_lo <= points.win_hi)
                         ? 16'($urandom_range(points.win_hi, points.win_lo))
                         : 16'($urandom);
        endcase
        send_pixel(12'($urandom), 12'($urandom), d, 8'($urandom), 8'($urandom),
                   8'($urandom));
    endtask

    task automatic random_config();
        logic [15:0] lo, hi;
        lo = 16'($urandom_range(3000));
        hi = 16'($urandom_range(65535, lo));
        write_reg(REG_WIN_LO, lo);
        write_reg(REG_WIN_HI, hi);
        write_reg(REG_PP_COL, 16'($urandom_range(4095)));
        write_reg(REG_PP_ROW, 16'($urandom_range(4095)));
        write_reg(REG_FOCAL_PX, 16'($urandom_range(4095)));
        write_reg(REG_RADIUS_MM, 16'($urandom_range(255)));
    endtask

    initial
    begin
        points.load_defaults();
        idle_cycles = 0;
        calm_stretch = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pixels with the reset registers: missing depth, window edges,
        // out-of-window depth, corner coordinates and colour extremes.
        send_pixel(12'd320, 12'd240, 16'd0, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd0, 12'd0, 16'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 16'd2000, 8'd255, 8'd128, 8'd1);
        send_pixel(12'd0, 12'd4095, 16'd2001, 8'd10, 8'd20, 8'd30);
        send_pixel(12'd320, 12'd240, 16'd1000, 8'd170, 8'd85, 8'd255);
        drain();

        // Focal length and radius of zero count as one; the widest window and
        // the far principal point drive positions into saturation.
        write_reg(REG_FOCAL_PX, 16'd0);
        write_reg(REG_RADIUS_MM, 16'd0);
        write_reg(REG_WIN_HI, 16'hFFFF);
        write_reg(REG_PP_COL, 16'd4095);
        write_reg(REG_PP_ROW, 16'd0);
        send_pixel(12'd0, 12'd4095, 16'hFFFF, 8'd255, 8'd0, 8'd255);
        send_pixel(12'd4095, 12'd0, 16'd1, 8'd1, 8'd2, 8'd3);
        send_pixel(12'd0, 12'd4095, 16'd1, 8'd4, 8'd5, 8'd6);
        drain();

        // Largest focal length and radius: tiny density, huge pixel radius.
        write_reg(REG_FOCAL_PX, 16'd4095);
        write_reg(REG_RADIUS_MM, 16'd255);
        write_reg(REG_WIN_LO, 16'd1);
        send_pixel(12'd4095, 12'd0, 16'd1, 8'd7, 8'd8, 8'd9);
        send_pixel(12'd0, 12'd4095, 16'hFFFF, 8'd255, 8'd255, 8'd0);
        send_pixel(12'd2047, 12'd2048, 16'd2, 8'd0, 8'd255, 8'd0);
        drain();

        // An empty window rejects everything, including its own bounds.
        write_reg(REG_WIN_LO, 16'd5000);
        write_reg(REG_WIN_HI, 16'd4000);
        send_pixel(12'd1, 12'd1, 16'd4000, 8'd1, 8'd1, 8'd1);
        send_pixel(12'd1, 12'd1, 16'd5000, 8'd1, 8'd1, 8'd1);
        send_pixel(12'd1, 12'd1, 16'd4500, 8'd1, 8'd1, 8'd1);
        drain();

        // Writes to indexes beyond the last register are ignored.
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h0000);
        write_reg(REG_WIN_LO, 16'd0);
        write_reg(REG_WIN_HI, 16'hFFFF);
        send_pixel(12'd100, 12'd200, 16'd300, 8'd40, 8'd50, 8'd60);
        drain();

        // Random phases; the first runs without any idling, later ones idle at
        // random. Each phase ends with the pipeline drained before new settings.
        for (int phase = 0; phase < 12; phase++) begin
            calm_stretch = (phase == 0);
            if (phase != 0)
                random_config();
            for (int n = 0; n < 95; n++)
                random_pixel();
            drain();
        end

        if (points.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
